// ===== design/hrp_pkg.sv =====
// Package for the HEX record parser: parse phase codes, result kinds, special
// characters, result and push types, and the ASCII hex digit decoder.
// No dependencies.
package hrp_pkg;

	// Parse phase, one-hot.
	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_COUNT = 6'b000010,
		PH_ADDR  = 6'b000100,
		PH_TYPE  = 6'b001000,
		PH_DATA  = 6'b010000,
		PH_CSUM  = 6'b100000
	} phase_t;

	// Result kinds.
	localparam logic [1:0] KIND_DATA     = 2'd0;
	localparam logic [1:0] KIND_CSUM     = 2'd1;
	localparam logic [1:0] KIND_NO_COLON = 2'd2;
	localparam logic [1:0] KIND_BAD_HEX  = 2'd3;

	// Characters with a meaning of their own.
	localparam logic [7:0] COLON_CHAR = 8'h3A;
	localparam logic [7:0] CR_CHAR    = 8'h0D;
	localparam logic [7:0] LF_CHAR    = 8'h0A;

	// One result transaction.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       last;
	} result_t;

	// Results produced by one character: count is 0, 1 or 2.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	// Decodes an ASCII hex digit: bit 4 set when valid, low nibble is the value.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

// ===== design/hrp_parse.sv =====
// Character decoder of the HEX record parser: input register, record state
// and the per-character parse logic that produces up to two results.
// Depends on hrp_pkg.
module hrp_parse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     char_in,
	input  logic           room,
	output hrp_pkg::push_t push
);
	import hrp_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       fire;

	phase_t     phase_q, phase_d;
	logic [1:0] digit_index_q, digit_index_d;
	logic [3:0] high_nibble_q, high_nibble_d;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic [7:0] sum_acc_q, sum_acc_d;

	logic [4:0] hex;
	logic [7:0] byte_val;
	logic [7:0] sum_next;
	logic [7:0] left_next;
	push_t      push_d;

	// The input register advances whenever the result queue can take two results.
	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
		end
	end

	// Shared decode of the registered character.
	assign hex       = hex_digit(char_s1);
	assign byte_val  = {high_nibble_q, hex[3:0]};
	assign sum_next  = sum_acc_q + byte_val;
	assign left_next = bytes_left_q - 8'd1;

	// Parse logic: next state and results for the registered character.
	always_comb begin
		phase_d       = phase_q;
		digit_index_d = digit_index_q;
		high_nibble_d = high_nibble_q;
		bytes_left_d  = bytes_left_q;
		sum_acc_d     = sum_acc_q;
		push_d        = '0;

		unique case (phase_q)
			PH_CSUM: begin
				// The record's own checksum digits are consumed unchecked.
				if (digit_index_q == 2'd0) begin
					digit_index_d = 2'd1;
				end else begin
					digit_index_d = 2'd0;
					phase_d       = PH_IDLE;
				end
			end
			PH_COUNT: begin
				if (!hex[4]) begin
					phase_d       = PH_IDLE;
					digit_index_d = 2'd0;
					push_d.count  = 2'd1;
					push_d.first  = '{kind: KIND_BAD_HEX, value: 8'd0, last: 1'b1};
				end else if (!digit_index_q[0]) begin
					high_nibble_d = hex[3:0];
					digit_index_d = digit_index_q + 2'd1;
				end else begin
					sum_acc_d     = sum_next;
					bytes_left_d  = byte_val;
					phase_d       = PH_ADDR;
					digit_index_d = 2'd0;
				end
			end
			PH_ADDR: begin
				if (!hex[4]) begin
					phase_d       = PH_IDLE;
					digit_index_d = 2'd0;
					push_d.count  = 2'd1;
					push_d.first  = '{kind: KIND_BAD_HEX, value: 8'd0, last: 1'b1};
				end else if (!digit_index_q[0]) begin
					high_nibble_d = hex[3:0];
					digit_index_d = digit_index_q + 2'd1;
				end else begin
					// Both address bytes go into the sum.
					sum_acc_d = sum_next;
					if (digit_index_q == 2'd3) begin
						phase_d       = PH_TYPE;
						digit_index_d = 2'd0;
					end else begin
						digit_index_d = digit_index_q + 2'd1;
					end
				end
			end
			PH_TYPE: begin
				if (!hex[4]) begin
					phase_d       = PH_IDLE;
					digit_index_d = 2'd0;
					push_d.count  = 2'd1;
					push_d.first  = '{kind: KIND_BAD_HEX, value: 8'd0, last: 1'b1};
				end else if (!digit_index_q[0]) begin
					high_nibble_d = hex[3:0];
					digit_index_d = digit_index_q + 2'd1;
				end else begin
					sum_acc_d     = sum_next;
					digit_index_d = 2'd0;
					if (bytes_left_q == 8'd0) begin
						// An empty record ends with its checksum right here.
						phase_d      = PH_CSUM;
						push_d.count = 2'd1;
						push_d.first = '{kind: KIND_CSUM, value: 8'(8'd0 - sum_next),
							last: 1'b1};
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (!hex[4]) begin
					phase_d       = PH_IDLE;
					digit_index_d = 2'd0;
					push_d.count  = 2'd1;
					push_d.first  = '{kind: KIND_BAD_HEX, value: 8'd0, last: 1'b1};
				end else if (!digit_index_q[0]) begin
					high_nibble_d = hex[3:0];
					digit_index_d = digit_index_q + 2'd1;
				end else begin
					sum_acc_d     = sum_next;
					digit_index_d = 2'd0;
					bytes_left_d  = left_next;
					push_d.count  = 2'd1;
					push_d.first  = '{kind: KIND_DATA, value: byte_val, last: 1'b0};
					if (left_next == 8'd0) begin
						// The last data byte is followed by the checksum.
						phase_d       = PH_CSUM;
						push_d.count  = 2'd2;
						push_d.second = '{kind: KIND_CSUM, value: 8'(8'd0 - sum_next),
							last: 1'b1};
					end
				end
			end
			default: begin
				// Idle: wait for the start colon, line ends pass silently.
				phase_d = PH_IDLE;
				if (char_s1 == COLON_CHAR) begin
					phase_d       = PH_COUNT;
					digit_index_d = 2'd0;
					high_nibble_d = 4'd0;
					bytes_left_d  = 8'd0;
					sum_acc_d     = 8'd0;
				end else if (char_s1 != CR_CHAR && char_s1 != LF_CHAR) begin
					push_d.count = 2'd1;
					push_d.first = '{kind: KIND_NO_COLON, value: 8'd0, last: 1'b1};
				end
			end
		endcase
	end

	// Record state advances once per parsed character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			digit_index_q <= 2'd0;
			high_nibble_q <= 4'd0;
			bytes_left_q  <= 8'd0;
			sum_acc_q     <= 8'd0;
		end else if (fire) begin
			phase_q       <= phase_d;
			digit_index_q <= digit_index_d;
			high_nibble_q <= high_nibble_d;
			bytes_left_q  <= bytes_left_d;
			sum_acc_q     <= sum_acc_d;
		end
	end

	// Results reach the queue only for a character that is parsed this cycle.
	always_comb begin
		push = push_d;
		if (!fire) begin
			push.count = 2'd0;
		end
	end

endmodule

// ===== design/hrp_out_fifo.sv =====
// Result queue of the HEX record parser: takes up to two results a cycle,
// hands out one result transaction a cycle while one is queued and out_ready is high.
// Depends on hrp_pkg.
module hrp_out_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hrp_pkg::push_t   push,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output hrp_pkg::result_t out_result
);
	import hrp_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	result_t            mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q, wr_next;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

	// Room is judged on the current fill, so it never waits on the output side.
	assign room       = count_q <= CNT_W'(DEPTH - 2);
	assign out_valid  = count_q != '0;
	assign pop        = out_valid && out_ready;
	assign out_result = mem[rd_ptr_q];
	assign wr_next    = ptr_inc(wr_ptr_q);

	// Storage writes, one or two entries.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem[wr_next] <= push.second;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.count == 2'd1) begin
				wr_ptr_q <= wr_next;
			end else if (push.count == 2'd2) begin
				wr_ptr_q <= ptr_inc(wr_next);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	// The fill never passes the depth.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue overflow");

	// A character never yields more than two results.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("illegal push count");

	// Results are pushed only when room was offered.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room)
		else $error("push without room");

	// A pop with nothing else going on lowers the fill by one.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.count == 2'd0 |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("fill count out of step");

endmodule

// ===== design/hex_record_parser.sv =====
// HEX record parser: characters in; data bytes, checksums and errors out.
// A result passes through the input register and the result queue; the
// checksum that follows a last data byte is queued with it and leaves after it.
// Throughput: one character per cycle; the input stalls only while the result
// queue holds more than FIFO_DEPTH - 2 results.
// Reset (arst_n low, asynchronous): parser idle, queue empty, no valid output.
module hex_record_parser #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_in
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] value
	output logic [1:0] m_axis_tuser,   // [1:0] kind
	output logic       m_axis_tlast    // last
);
	import hrp_pkg::*;

	push_t   push;
	logic    room;
	result_t out_result;

	hrp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.char_in  (s_axis_tdata),
		.room     (room),
		.push     (push)
	);

	hrp_out_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (out_result)
	);

	// Output transaction fields.
	assign m_axis_tdata = out_result.value;
	assign m_axis_tuser = out_result.kind;
	assign m_axis_tlast = out_result.last;

endmodule

// ===== tb/hex_record_parser_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for hex_record_parser: streams record text in and
// checks every data byte, checksum and error report against a local predictor.
// Depends on hrp_pkg and hex_record_parser.

module hex_record_parser_test;
	import hrp_pkg::*;

	// Value of an ASCII hex digit, or -1 for any other character.
	function automatic int ascii_hex_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		return -1;
	endfunction

	// Tracks the parse of the character stream and holds the results still owed.
	class record_scoreboard;
		phase_t     phase;
		logic [1:0] digit_pos;
		logic [3:0] high_nib;
		logic [7:0] bytes_left;
		logic [7:0] byte_sum;
		result_t    owed_results[$];
		int         errors;

		function new();
			phase = PH_IDLE;
			digit_pos = '0;
			high_nib = '0;
			bytes_left = '0;
			byte_sum = '0;
			errors = 0;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function void owe(logic [1:0] kind, logic [7:0] value, logic last);
			result_t r;
			r.kind = kind;
			r.value = value;
			r.last = last;
			owed_results.push_back(r);
		endfunction

		// The computed checksum closes the record; its two text digits follow.
		function void close_record();
			owe(KIND_CSUM, 8'(-byte_sum), 1'b1);
			phase = PH_CSUM;
			digit_pos = '0;
		endfunction

		// Advances the parse by one accepted character.
		function void note_char(logic [7:0] c);
			int h;
			logic [7:0] b;
			if (phase == PH_CSUM) begin
				if (digit_pos == 0) begin
					digit_pos = 2'd1;
				end else begin
					digit_pos = '0;
					phase = PH_IDLE;
				end
				return;
			end
			if (phase == PH_IDLE) begin
				if (c == CR_CHAR || c == LF_CHAR) return;
				if (c == COLON_CHAR) begin
					phase = PH_COUNT;
					digit_pos = '0;
					high_nib = '0;
					bytes_left = '0;
					byte_sum = '0;
					return;
				end
				owe(KIND_NO_COLON, 8'h00, 1'b1);
				return;
			end
			h = ascii_hex_value(c);
			if (h < 0) begin
				phase = PH_IDLE;
				digit_pos = '0;
				owe(KIND_BAD_HEX, 8'h00, 1'b1);
				return;
			end
			// First digit of a pair only sets the high nibble.
			if (!digit_pos[0]) begin
				high_nib = h[3:0];
				digit_pos = digit_pos + 2'd1;
				return;
			end
			b = {high_nib, h[3:0]};
			byte_sum = byte_sum + b;
			case (phase)
				PH_COUNT: begin
					bytes_left = b;
					phase = PH_ADDR;
					digit_pos = '0;
				end
				PH_ADDR: begin
					if (digit_pos == 2'd3) begin
						phase = PH_TYPE;
						digit_pos = '0;
					end else begin
						digit_pos = digit_pos + 2'd1;
					end
				end
				PH_TYPE: begin
					digit_pos = '0;
					if (bytes_left == 0) close_record();
					else phase = PH_DATA;
				end
				default: begin
					digit_pos = '0;
					owe(KIND_DATA, b, 1'b0);
					bytes_left = bytes_left - 8'd1;
					if (bytes_left == 0) close_record();
				end
			endcase
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) $display("%0t: %s", $time, msg);
		endfunction

		// Compares one result transaction with the oldest result owed.
		function void check_result(logic [1:0] kind, logic [7:0] value, logic last);
			result_t want;
			if (owed_results.size() == 0) begin
				flag($sformatf("unexpected result kind %0d value %02h last %0b",
					kind, value, last));
				return;
			end
			want = owed_results.pop_front();
			if (want.kind !== kind || want.value !== value || want.last !== last) begin
				flag($sformatf("expected kind %0d value %02h last %0b, got kind %0d value %02h last %0b",
					want.kind, want.value, want.last, kind, value, last));
			end
		endfunction
	endclass

	localparam int CHAR_TARGET    = 1250;
	localparam int HOLD_START     = 600;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 2000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;   // [7:0] char_in
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;   // [7:0] value
	logic [1:0] m_axis_tuser;   // [1:0] kind
	logic       m_axis_tlast;   // last

	record_scoreboard board;
	logic [7:0]       record_text[$];
	int               chars_sent = 0;
	int               burst_left = 0;
	int               idle_cycles = 0;

	hex_record_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	// Random-case ASCII digit for a nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + n;
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
	endfunction

	function automatic void append_byte(input logic [7:0] b);
		record_text.push_back(hex_char(b[7:4]));
		record_text.push_back(hex_char(b[3:0]));
	endfunction

	// Offers one character in bursts; called and returns at a falling edge.
	task automatic send_char(input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_char(c);
		chars_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i]);
	endtask

	// Builds one record, mostly well formed, sometimes broken by a non-hex digit.
	task automatic send_record();
		logic [7:0] count;
		logic [7:0] b;
		logic [7:0] sum;
		logic [7:0] junk;
		int body_len;
		int pos;
		record_text.delete();
		if ($urandom_range(0, 49) == 0) begin
			count = $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(9, 64));
		end else begin
			count = 8'($urandom_range(0, 8));
		end
		record_text.push_back(COLON_CHAR);
		append_byte(count);
		sum = count;
		// Address high, address low and record type, then the data bytes.
		for (int i = 0; i < 3 + count; i++) begin
			b = (i == 2) ? 8'($urandom_range(0, 5)) : 8'($urandom);
			append_byte(b);
			sum = sum + b;
		end
		body_len = record_text.size();
		// The checksum digits are skipped by the block; now and then send junk.
		if ($urandom_range(0, 7) == 0) begin
			record_text.push_back(8'($urandom));
			record_text.push_back(8'($urandom));
		end else begin
			append_byte(-sum);
		end
		if ($urandom_range(0, 1)) record_text.push_back(CR_CHAR);
		if ($urandom_range(0, 1)) record_text.push_back(LF_CHAR);
		if ($urandom_range(0, 7) == 0) begin
			pos = $urandom_range(1, body_len - 1);
			do junk = 8'($urandom); while (ascii_hex_value(junk) >= 0);
			record_text[pos] = junk;
			record_text = record_text[0:pos];
		end
		foreach (record_text[i]) send_char(record_text[i]);
	endtask

	// Result receiver: segments of free flow, light and heavy stalls, and one
	// long hold-off so the parser fills and stalls its input.
	initial begin
		int cycle;
		int seg_left;
		int mode;
		logic ready;
		cycle = 0;
		seg_left = 0;
		mode = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cycle++;
			if (seg_left == 0) begin
				mode = $urandom_range(0, 2);
				seg_left = $urandom_range(20, 150);
			end
			seg_left--;
			case (mode)
				0: ready = 1'b1;
				1: ready = $urandom_range(0, 1);
				default: ready = ($urandom_range(0, 3) == 0);
			endcase
			if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES) ready = 1'b0;
			m_axis_tready <= ready;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			board.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
		end
	end

	// Watchdog on cycles in which no transaction moves on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Reset, directed cases, random records, then drain.
	initial begin
		logic [7:0] c;
		board = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Line endings while idle, then characters without a start colon.
		send_char(CR_CHAR);
		send_char(LF_CHAR);
		send_char(8'h78);
		send_char(8'hFF);
		// Zero byte count: checksum right after the type, then skipped digits.
		send_text(":00000001FF");
		// Bad digit in the address, then in the byte count.
		send_text(":01aBg");
		send_char(COLON_CHAR);
		send_char(8'h00);

		while (chars_sent < CHAR_TARGET) begin
			// Idle noise between records is drawn from every character code.
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					c = 8'($urandom);
					send_char(c);
				end
			end
			send_record();
		end
		s_axis_tvalid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/hrp_pkg.sv
design/hrp_parse.sv
design/hrp_out_fifo.sv
design/hex_record_parser.sv
tb/hex_record_parser_test.sv
